/* hw/rtl/ips_pkg.sv */
// Package: pattern table, class bits and status codes for the injection pattern scanner.
package ips_pkg;

  localparam int WIN_PREV  = 11;
  localparam int WIN_LEN   = 12;
  localparam int PAT_COUNT = 15;
  localparam int CLS_W     = 4;
  localparam int STATUS_W  = 3;

  typedef logic [PAT_COUNT-1:0]   eq_vec_t;
  typedef logic [CLS_W-1:0]       cls_t;
  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [WIN_LEN*8-1:0]   pat_text_t;

  localparam cls_t CLS_SQL    = 4'h1;
  localparam cls_t CLS_SCRIPT = 4'h2;
  localparam cls_t CLS_CTRL   = 4'h4;
  localparam cls_t CLS_PATH   = 4'h8;

  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_EMPTY  = 3'd1;
  localparam status_t ST_SQL    = 3'd2;
  localparam status_t ST_SCRIPT = 3'd3;
  localparam status_t ST_CTRL   = 3'd4;
  localparam status_t ST_PATH   = 3'd5;

  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  // right-justified: last character in bits [7:0]
  localparam pat_text_t PAT_TEXT [PAT_COUNT] = '{
    96'("' OR "),
    96'("'; DROP"),
    96'("'; DELETE"),
    96'("'; INSERT"),
    96'("UNION SELECT"),
    96'("--"),
    96'("/*"),
    96'("*/"),
    96'("<script"),
    96'("javascript:"),
    96'("onerror="),
    96'("onload="),
    96'("../"),
    96'("..\\"),
    96'("%2e%2e")
  };

  localparam int PAT_LEN [PAT_COUNT] = '{5, 7, 9, 9, 12, 2, 2, 2, 7, 11, 8, 7, 3, 3, 6};

  localparam cls_t PAT_CLS [PAT_COUNT] = '{
    CLS_SQL, CLS_SQL, CLS_SQL, CLS_SQL, CLS_SQL, CLS_SQL, CLS_SQL, CLS_SQL,
    CLS_SCRIPT, CLS_SCRIPT, CLS_SCRIPT, CLS_SCRIPT,
    CLS_PATH, CLS_PATH, CLS_PATH
  };

endpackage

/* hw/rtl/ips_cell.sv */
// Window cell: holds one previous byte, passes it on, compares it to every pattern.
module ips_cell #(
  parameter int K = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic                  clear,
  input  logic [7:0]            byte_in,
  output logic [7:0]            byte_out,
  output ips_pkg::eq_vec_t      eq
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (clear) begin
      byte_nxt = 8'h00;
    end else if (shift_en) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

  // a cell older than the pattern's reach does not take part
  always_comb begin
    for (int p = 0; p < ips_pkg::PAT_COUNT; p++) begin
      if (K <= ips_pkg::PAT_LEN[p] - 2) begin
        eq[p] = (byte_r == ips_pkg::PAT_TEXT[p][8*(K+1) +: 8]);
      end else begin
        eq[p] = 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/ips_match.sv */
// Match combiner: joins the cell compares with the current byte into class hits.
module ips_match (
  input  logic [7:0]            cur_byte,
  input  ips_pkg::eq_vec_t      cell_eq [ips_pkg::WIN_PREV],
  output ips_pkg::cls_t         hits
);

  ips_pkg::eq_vec_t pat_hit;
  logic             ctrl_hit;

  always_comb begin
    for (int p = 0; p < ips_pkg::PAT_COUNT; p++) begin
      pat_hit[p] = (cur_byte == ips_pkg::PAT_TEXT[p][7:0]);
      for (int k = 0; k < ips_pkg::WIN_PREV; k++) begin
        pat_hit[p] = pat_hit[p] & cell_eq[k][p];
      end
    end
  end

  assign ctrl_hit = (cur_byte < ips_pkg::BYTE_SPACE) && (cur_byte != ips_pkg::BYTE_TAB) &&
                    (cur_byte != ips_pkg::BYTE_LF) && (cur_byte != ips_pkg::BYTE_CR);

  always_comb begin
    hits = ctrl_hit ? ips_pkg::CLS_CTRL : '0;
    for (int p = 0; p < ips_pkg::PAT_COUNT; p++) begin
      if (pat_hit[p]) begin
        hits = hits | ips_pkg::PAT_CLS[p];
      end
    end
  end

endmodule

/* hw/rtl/injection_pattern_scanner.sv */
// Top level of the injection pattern scanner.
// Scans a string at most one byte per transfer and reports one status on the string's last transfer.
// One item per clock: each accepted byte shifts through a chain of eleven byte cells that
// compare in parallel against the pattern table, so the next item is taken in the next cycle;
// the status appears in an output register in the cycle after the last item; input is held
// off only while that register is full and stalled. check_mask is sampled when the status is
// formed. The user must write it only while idle; the block does not enforce this.
module injection_pattern_scanner (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_has_byte,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_is_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_check_mask
);

  logic                  accept;
  logic                  shift_en;
  logic                  clear;
  logic [7:0]            chain [ips_pkg::WIN_PREV+1];
  ips_pkg::eq_vec_t      cell_eq [ips_pkg::WIN_PREV];
  ips_pkg::cls_t         new_hits;

  ips_pkg::cls_t         hits_r, hits_nxt, active;
  logic                  seen_r, seen_nxt;
  logic [3:0]            mask_r, mask_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ips_pkg::status_t      status_r, status_nxt;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign shift_en  = accept && in_has_byte;
  assign clear     = accept && in_is_last;
  assign cfg_ready = 1'b1;

  assign chain[0] = in_text_byte;

  for (genvar k = 0; k < ips_pkg::WIN_PREV; k++) begin : g_cell
    ips_cell #(.K(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .clear    (clear),
      .byte_in  (chain[k]),
      .byte_out (chain[k+1]),
      .eq       (cell_eq[k])
    );
  end

  ips_match u_match (
    .cur_byte (in_text_byte),
    .cell_eq  (cell_eq),
    .hits     (new_hits)
  );

  always_comb begin
    hits_nxt = hits_r | (shift_en ? new_hits : '0);
    seen_nxt = seen_r | shift_en;
    active   = hits_nxt & mask_r;

    if (!seen_nxt) begin
      status_nxt = ips_pkg::ST_EMPTY;
    end else if ((active & ips_pkg::CLS_SQL) != '0) begin
      status_nxt = ips_pkg::ST_SQL;
    end else if ((active & ips_pkg::CLS_SCRIPT) != '0) begin
      status_nxt = ips_pkg::ST_SCRIPT;
    end else if ((active & ips_pkg::CLS_CTRL) != '0) begin
      status_nxt = ips_pkg::ST_CTRL;
    end else if ((active & ips_pkg::CLS_PATH) != '0) begin
      status_nxt = ips_pkg::ST_PATH;
    end else begin
      status_nxt = ips_pkg::ST_OK;
    end
    if (!clear) begin
      status_nxt = status_r;
    end

    if (clear) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end

    mask_nxt = (cfg_valid && cfg_ready) ? cfg_check_mask : mask_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      seen_r      <= 1'b0;
      mask_r      <= 4'hF;
      out_valid_r <= 1'b0;
    end else begin
      hits_r      <= clear ? '0 : hits_nxt;
      seen_r      <= clear ? 1'b0 : seen_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;

endmodule

/* hw/rtl/ips_checker.sv */
// Port checker for the injection pattern scanner, bound to the top level.
module ips_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ips_pkg::ST_PATH))
    else $error("status out of range");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_last |=> out_valid)
    else $error("last transfer gave no result");

  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled with output free");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind injection_pattern_scanner ips_checker u_ips_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_is_last (in_is_last),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status)
);
